/* design/orbcam_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Orbit camera package
// Operation codes, register indexes, fixed-point constants and the CORDIC
// arctangent table shared by the orbit camera position block.
// ----------------------------------------------------------------------------
package orbcam_pkg;

  // Event codes carried in the operation field.
  typedef enum logic [1:0] {
    OP_ROTATE   = 2'd0,
    OP_ZOOM     = 2'd1,
    OP_RETARGET = 2'd2,
    OP_RESET    = 2'd3
  } op_t;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_SENSITIVITY  = 3'd0,
    REG_MIN_DISTANCE = 3'd1,
    REG_MAX_DISTANCE = 3'd2,
    REG_MIN_PHI      = 3'd3,
    REG_MAX_PHI      = 3'd4,
    REG_DEF_DISTANCE = 3'd5,
    REG_DEF_THETA    = 3'd6,
    REG_DEF_PHI      = 3'd7
  } reg_idx_t;

  // 2*pi in Q4.12.
  localparam logic [14:0] TWO_PI_Q12 = 15'd25736;

  // Angle constants in Q2.30, held at the width of the angle accumulator.
  localparam logic signed [35:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [35:0] TWO_PI_Q30  = 36'sd6746518852;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

  // CORDIC start vector length (1/K) in Q2.30.
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  // 2^40 divided by 2*pi in Q4.12, rounded down. The quotient estimate it
  // gives for theta is never more than one below the true quotient.
  localparam logic [25:0] WRAP_RECIP = 26'd42722708;

  localparam int ATAN_COUNT = 24;

  // Arctangent of 2^-i in Q2.30.
  localparam logic [31:0] ATAN_Q30 [ATAN_COUNT] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

endpackage

/* design/orbit_camera_position_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Orbit camera position
// Keeps azimuth, polar angle, distance and target, applies one event per
// beat and returns the eye position from a serial CORDIC and a shared
// multiplier.
// ----------------------------------------------------------------------------
// Events are taken only while the sequencer is idle, so a new event waits until
// the previous result has gone to the output register; the CORDIC loop runs
// twice per event, rotate and reset events also pass through the theta wrap
// states, and a stalled result holds the sequencer in its final state.
// Reset: synchronous and active high; registers and camera state return to
// their defaults and the block is idle.
module orbit_camera_position_top #(
  parameter int CORDIC_STEPS = 16,
  parameter int COORD_BITS   = 21
) (
  input  logic                         clk,
  input  logic                         rst,
  // Event channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic signed [15:0]           delta_x,
  input  logic signed [15:0]           delta_y,
  input  logic signed [16:0]           zoom_step,
  input  logic signed [20:0]           target_x,
  input  logic signed [20:0]           target_y,
  input  logic signed [20:0]           target_z,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] eye_x,
  output logic signed [COORD_BITS-1:0] eye_y,
  output logic signed [COORD_BITS-1:0] eye_z,
  output logic [14:0]                  theta_out,
  output logic signed [15:0]           phi_out,
  output logic [15:0]                  distance_out,
  // Register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [4:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import orbcam_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MUL_DX, ST_MUL_DY, ST_PHI, ST_ZOOM, ST_RSTEV,
    ST_WRAP_PREP, ST_WRAP_MQ, ST_WRAP_MM, ST_WRAP_SUB, ST_WRAP_FIX, ST_WRAP_FIN,
    ST_LOAD, ST_RED, ST_FOLD, ST_ITER, ST_SAVE,
    ST_MUL_S0, ST_MUL_S2, ST_MUL_O0, ST_MUL_O1, ST_MUL_O2, ST_OFF2, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    WM_NONE, WM_POS, WM_NEG
  } wrap_mode_t;

  state_t     state;
  wrap_mode_t wmode;

  // Configuration registers
  logic [15:0]        sensitivity, min_distance, max_distance, default_distance;
  logic signed [15:0] min_phi, max_phi, default_theta, default_phi;

  // Camera state
  logic [14:0]        cur_theta;
  logic signed [15:0] cur_phi;
  logic [15:0]        cur_distance;
  logic signed [20:0] tgt_x, tgt_y, tgt_z;

  // Latched event fields
  logic signed [15:0] dx_q, dy_q;
  logic signed [16:0] dd_q;

  // Working registers
  logic signed [30:0] tsum;
  logic [29:0]        rem;
  logic [4:0]         cnt;
  logic               sel;
  logic               neg;
  logic signed [35:0] z;
  logic signed [33:0] x, y;
  logic signed [33:0] sp, cp, st, ct;
  logic signed [32:0] s0, s2;
  logic signed [17:0] off0, off1, off2;
  logic signed [65:0] prod;

  // Combinational helpers
  logic signed [32:0] mul_a, mul_b;
  logic signed [30:0] dang;
  logic signed [31:0] phi_src, phi_lo, phi_hi, phi_c1, phi_c2;
  logic signed [17:0] dist_raw, dist_lo, dist_hi, dist_c1, dist_c2;
  logic [15:0]        angle_in;
  logic signed [35:0] atan_v;
  logic signed [33:0] x_sh, y_sh, sin_v, cos_v;
  logic signed [17:0] off_new;
  logic               acc_in, cfg_wr;

  assign acc_in   = in_valid && !in_stall;
  assign in_stall = (state != ST_IDLE);
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // Register read-back.
  always_comb begin
    case (reg_idx_t'(paddr[4:2]))
      REG_SENSITIVITY:  prdata = {16'b0, sensitivity};
      REG_MIN_DISTANCE: prdata = {16'b0, min_distance};
      REG_MAX_DISTANCE: prdata = {16'b0, max_distance};
      REG_MIN_PHI:      prdata = {16'b0, min_phi};
      REG_MAX_PHI:      prdata = {16'b0, max_phi};
      REG_DEF_DISTANCE: prdata = {16'b0, default_distance};
      REG_DEF_THETA:    prdata = {16'b0, default_theta};
      REG_DEF_PHI:      prdata = {16'b0, default_phi};
      default:          prdata = 32'b0;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      ST_MUL_DX: begin
        mul_a = $signed({{17{dx_q[15]}}, dx_q});
        mul_b = $signed({17'b0, sensitivity});
      end
      ST_MUL_DY: begin
        mul_a = $signed({{17{dy_q[15]}}, dy_q});
        mul_b = $signed({17'b0, sensitivity});
      end
      // Quotient estimate of theta by 2*pi, then the multiple to take away.
      ST_WRAP_MQ: begin
        mul_a = $signed({3'b0, rem});
        mul_b = $signed({7'b0, WRAP_RECIP});
      end
      ST_WRAP_MM: begin
        mul_a = $signed({19'b0, prod[53:40]});
        mul_b = $signed({18'b0, TWO_PI_Q12});
      end
      ST_MUL_S0: begin
        mul_a = sp[32:0];
        mul_b = ct[32:0];
      end
      ST_MUL_S2: begin
        mul_a = sp[32:0];
        mul_b = st[32:0];
      end
      ST_MUL_O0: begin
        mul_a = $signed({17'b0, cur_distance});
        mul_b = s0;
      end
      ST_MUL_O1: begin
        mul_a = $signed({17'b0, cur_distance});
        mul_b = cp[32:0];
      end
      ST_MUL_O2: begin
        mul_a = $signed({17'b0, cur_distance});
        mul_b = s2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Angle step from a drag product, Q.16 down to Q.12 with floor rounding.
  assign dang = 31'(prod >>> 4);

  // Phi clamp: raise to the minimum first, so the maximum wins when inverted.
  always_comb begin
    if (state == ST_RSTEV) begin
      phi_src = 32'(default_phi);
    end else begin
      phi_src = 32'(cur_phi) - 32'(dang);
    end
    phi_lo = 32'(min_phi);
    phi_hi = 32'(max_phi);
    phi_c1 = (phi_src < phi_lo) ? phi_lo : phi_src;
    phi_c2 = (phi_c1 > phi_hi) ? phi_hi : phi_c1;
  end

  function automatic logic signed [17:0] delta_to_ext(input logic signed [16:0] d);
    delta_to_ext = {d[16], d};
  endfunction

  // Distance clamp for zoom events.
  always_comb begin
    dist_raw = $signed({2'b0, cur_distance}) + 18'(delta_to_ext(dd_q));
    dist_lo  = $signed({2'b0, min_distance});
    dist_hi  = $signed({2'b0, max_distance});
    dist_c1  = (dist_raw < dist_lo) ? dist_lo : dist_raw;
    dist_c2  = (dist_c1 > dist_hi) ? dist_hi : dist_c1;
  end

  // CORDIC datapath.
  assign angle_in = sel ? {1'b0, cur_theta} : cur_phi;
  assign atan_v   = $signed({4'b0, ATAN_Q30[cnt]});
  assign x_sh     = x >>> cnt;
  assign y_sh     = y >>> cnt;
  assign sin_v    = neg ? -y : y;
  assign cos_v    = neg ? -x : x;
  assign off_new  = 18'((prod + 66'sd536870912) >>> 30);

  // Saturate a target plus offset to the coordinate range.
  function automatic logic signed [COORD_BITS-1:0] sat_sum(
    input logic signed [20:0] t,
    input logic signed [17:0] o
  );
    logic signed [33:0] s;
    logic signed [33:0] lim;
    s   = 34'(t) + 34'(o);
    lim = 34'sd1 <<< (COORD_BITS - 1);
    if (s > lim - 34'sd1) begin
      sat_sum = COORD_BITS'(lim - 34'sd1);
    end else if (s < -lim) begin
      sat_sum = COORD_BITS'(-lim);
    end else begin
      sat_sum = COORD_BITS'(s);
    end
  endfunction

  // Sequencer, camera state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      sensitivity      <= 16'd328;
      min_distance     <= 16'd256;
      max_distance     <= 16'd5120;
      min_phi          <= 16'sd410;
      max_phi          <= 16'sd12458;
      default_distance <= 16'd2560;
      default_theta    <= 16'sd0;
      default_phi      <= 16'sd6434;
      cur_theta        <= 15'd0;
      cur_phi          <= 16'sd6434;
      cur_distance     <= 16'd2560;
      tgt_x            <= '0;
      tgt_y            <= '0;
      tgt_z            <= '0;
      wmode            <= WM_NONE;
      cnt              <= '0;
      sel              <= 1'b0;
      neg              <= 1'b0;
    end else begin
      // Register writes from the configuration port.
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_SENSITIVITY:  sensitivity      <= pwdata[15:0];
          REG_MIN_DISTANCE: min_distance     <= pwdata[15:0];
          REG_MAX_DISTANCE: max_distance     <= pwdata[15:0];
          REG_MIN_PHI:      min_phi          <= pwdata[15:0];
          REG_MAX_PHI:      max_phi          <= pwdata[15:0];
          REG_DEF_DISTANCE: default_distance <= pwdata[15:0];
          REG_DEF_THETA:    default_theta    <= pwdata[15:0];
          REG_DEF_PHI:      default_phi      <= pwdata[15:0];
          default:          ;
        endcase
      end

      // The final state reloads the output itself, so it is not cleared there.
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      prod <= mul_a * mul_b;

      case (state)
        ST_IDLE: begin
          if (acc_in) begin
            dx_q <= delta_x;
            dy_q <= delta_y;
            dd_q <= zoom_step;
            sel  <= 1'b0;
            if (operation[1]) begin
              tgt_x <= target_x;
              tgt_y <= target_y;
              tgt_z <= target_z;
            end
            case (op_t'(operation))
              OP_ROTATE:   state <= ST_MUL_DX;
              OP_ZOOM:     state <= ST_ZOOM;
              OP_RETARGET: state <= ST_LOAD;
              OP_RESET:    state <= ST_RSTEV;
              default:     state <= ST_IDLE;
            endcase
          end
        end
        ST_MUL_DX: state <= ST_MUL_DY;
        ST_MUL_DY: begin
          tsum  <= $signed({16'b0, cur_theta}) + dang;
          state <= ST_PHI;
        end
        ST_PHI: begin
          cur_phi <= phi_c2[15:0];
          state   <= ST_WRAP_PREP;
        end
        ST_ZOOM: begin
          cur_distance <= dist_c2[15:0];
          state        <= ST_LOAD;
        end
        ST_RSTEV: begin
          cur_distance <= default_distance;
          cur_phi      <= phi_c2[15:0];
          tsum         <= 31'(default_theta);
          state        <= ST_WRAP_PREP;
        end
        // Sort theta into above, below or inside the wrap range.
        ST_WRAP_PREP: begin
          if (tsum > $signed({16'b0, TWO_PI_Q12})) begin
            wmode <= WM_POS;
            rem   <= 30'(tsum - 31'sd1);
            state <= ST_WRAP_MQ;
          end else if (tsum < 31'sd0) begin
            wmode <= WM_NEG;
            rem   <= 30'(-tsum);
            state <= ST_WRAP_MQ;
          end else begin
            wmode <= WM_NONE;
            rem   <= 30'(tsum);
            state <= ST_WRAP_FIN;
          end
        end
        // The multiplier forms the quotient estimate, then its multiple of 2*pi.
        ST_WRAP_MQ: state <= ST_WRAP_MM;
        ST_WRAP_MM: state <= ST_WRAP_SUB;
        ST_WRAP_SUB: begin
          rem   <= rem - prod[29:0];
          state <= ST_WRAP_FIX;
        end
        // The estimate may fall one short, which leaves one more 2*pi to remove.
        ST_WRAP_FIX: begin
          if (rem >= 30'(TWO_PI_Q12)) begin
            rem <= rem - 30'(TWO_PI_Q12);
          end
          state <= ST_WRAP_FIN;
        end
        ST_WRAP_FIN: begin
          case (wmode)
            WM_POS:  cur_theta <= 15'(rem + 30'd1);
            WM_NEG:  cur_theta <= (rem == 30'd0) ? 15'd0 : 15'(30'(TWO_PI_Q12) - rem);
            default: cur_theta <= 15'(rem);
          endcase
          state <= ST_LOAD;
        end
        // Angle into Q2.30.
        ST_LOAD: begin
          z     <= $signed({{2{angle_in[15]}}, angle_in, 18'b0});
          state <= ST_RED;
        end
        ST_RED: begin
          if (z > PI_Q30) begin
            z <= z - TWO_PI_Q30;
          end else if (z < -PI_Q30) begin
            z <= z + TWO_PI_Q30;
          end
          state <= ST_FOLD;
        end
        // Fold into the right half-plane and remember to negate.
        ST_FOLD: begin
          if (z > HALF_PI_Q30) begin
            z   <= z - PI_Q30;
            neg <= 1'b1;
          end else if (z < -HALF_PI_Q30) begin
            z   <= z + PI_Q30;
            neg <= 1'b1;
          end else begin
            neg <= 1'b0;
          end
          x     <= GAIN_Q30;
          y     <= '0;
          cnt   <= '0;
          state <= ST_ITER;
        end
        // One CORDIC micro-rotation per cycle.
        ST_ITER: begin
          if (z >= 36'sd0) begin
            x <= x - y_sh;
            y <= y + x_sh;
            z <= z - atan_v;
          end else begin
            x <= x + y_sh;
            y <= y - x_sh;
            z <= z + atan_v;
          end
          if (cnt == 5'(CORDIC_STEPS - 1)) begin
            state <= ST_SAVE;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        ST_SAVE: begin
          if (!sel) begin
            sp    <= sin_v;
            cp    <= cos_v;
            sel   <= 1'b1;
            state <= ST_LOAD;
          end else begin
            st    <= sin_v;
            ct    <= cos_v;
            state <= ST_MUL_S0;
          end
        end
        ST_MUL_S0: state <= ST_MUL_S2;
        ST_MUL_S2: begin
          s0    <= 33'(prod >>> 30);
          state <= ST_MUL_O0;
        end
        ST_MUL_O0: begin
          s2    <= 33'(prod >>> 30);
          state <= ST_MUL_O1;
        end
        ST_MUL_O1: begin
          off0  <= off_new;
          state <= ST_MUL_O2;
        end
        ST_MUL_O2: begin
          off1  <= off_new;
          state <= ST_OFF2;
        end
        ST_OFF2: begin
          off2  <= off_new;
          state <= ST_DONE;
        end
        // Hand the result to the output register once it is free.
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            eye_x        <= sat_sum(tgt_x, off0);
            eye_y        <= sat_sum(tgt_y, off1);
            eye_z        <= sat_sum(tgt_z, off2);
            theta_out    <= cur_theta;
            phi_out      <= cur_phi;
            distance_out <= cur_distance;
            out_valid    <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // An accepted event always starts the sequencer.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    acc_in |=> state != ST_IDLE)
    else $error("event accepted but sequencer stayed idle");

  // Theta stays inside the wrap range.
  a_theta_range: assert property (@(posedge clk) disable iff (rst)
    cur_theta <= TWO_PI_Q12)
    else $error("theta outside [0, 2pi]");

  // The CORDIC counter never passes the step count.
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_ITER |-> cnt < 5'(CORDIC_STEPS))
    else $error("CORDIC counter overran");

  // A result appears only from the final state.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside the final state");

endmodule

/* bench/orbit_camera_position_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Orbit camera position testbench
// Drives camera events with random idle gaps and output stalls, writes the
// limit and default registers between phases, and checks every eye position
// and camera state beat against a fixed-point CORDIC predictor.
// ----------------------------------------------------------------------------
module orbit_camera_position_top_test;
  import orbcam_pkg::*;

  localparam int STEPS = 16;
  localparam int CBITS = 21;
  localparam longint PI_Q = 64'sd3373259426;
  localparam longint HALF_PI_Q = 64'sd1686629713;
  localparam longint GAIN_Q = 64'sd652032874;
  localparam longint FULL_TURN = 64'sd25736;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [16:0] dd;
    logic signed [20:0] tx;
    logic signed [20:0] ty;
    logic signed [20:0] tz;
  } event_t;

  typedef struct packed {
    logic signed [20:0] ex;
    logic signed [20:0] ey;
    logic signed [20:0] ez;
    logic [14:0]        theta;
    logic signed [15:0] phi;
    logic [15:0]        distance;
  } pose_t;

  // Directed row: an event, and optionally a pose read off at a glance.
  typedef struct packed {
    event_t ev;
    logic   has_pose;
    pose_t  pose;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0, in_stall;
  logic [1:0] operation = '0;
  logic signed [15:0] delta_x = '0, delta_y = '0;
  logic signed [16:0] zoom_step = '0;
  logic signed [20:0] target_x = '0, target_y = '0, target_z = '0;
  logic out_valid, out_stall = 1'b0;
  logic signed [20:0] eye_x, eye_y, eye_z;
  logic [14:0] theta_out;
  logic signed [15:0] phi_out;
  logic [15:0] distance_out;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;

  logic [15:0] cam_reg [8];
  longint cam_theta, cam_phi, cam_dist;
  longint cam_target [3];
  pose_t pose_queue [$];
  bit failed = 0;
  bit stall_on = 1'b1;

  orbit_camera_position_top uut (.*);

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Limit on run time.
  initial begin
    #20ms;
    $display("[orbit_camera_position_top] ERROR");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_turn(longint t);
    longint r;
    if (t > FULL_TURN) return ((t - 1) % FULL_TURN) + 1;
    if (t < 0) begin
      r = t % FULL_TURN;
      return (r < 0) ? r + FULL_TURN : r;
    end
    return t;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic longint atan_entry(int i);
    return longint'(ATAN_Q30[i]);
  endfunction

  // Rotation-mode CORDIC for sine and cosine in Q2.30.
  task automatic cordic_sincos(input longint ang, output longint sn, output longint cs);
    longint z, x, y, nx;
    bit flip;
    z = ang * 262144;
    x = GAIN_Q;
    y = 0;
    flip = 0;
    while (z > PI_Q) z -= 2 * PI_Q;
    while (z < -PI_Q) z += 2 * PI_Q;
    if (z > HALF_PI_Q) begin
      z -= PI_Q;
      flip = 1;
    end else if (z < -HALF_PI_Q) begin
      z += PI_Q;
      flip = 1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z -= atan_entry(i);
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z += atan_entry(i);
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endtask

  // Applies one event to the camera copy and returns the resulting pose.
  task automatic advance_camera(input event_t ev, output pose_t p);
    longint sens, lo_phi, hi_phi, sp, cp, st, ct, lim;
    longint off [3];
    longint eye [3];
    sens = longint'(cam_reg[REG_SENSITIVITY]);
    lo_phi = longint'($signed(cam_reg[REG_MIN_PHI]));
    hi_phi = longint'($signed(cam_reg[REG_MAX_PHI]));
    case (op_t'(ev.operation))
      OP_ROTATE: begin
        cam_theta = wrap_turn(cam_theta + floor_shift(longint'(ev.dx) * sens, 4));
        cam_phi = clamp(cam_phi - floor_shift(longint'(ev.dy) * sens, 4), lo_phi, hi_phi);
      end
      OP_ZOOM: begin
        cam_dist = clamp(cam_dist + longint'(ev.dd), longint'(cam_reg[REG_MIN_DISTANCE]),
                         longint'(cam_reg[REG_MAX_DISTANCE]));
      end
      default: begin
        cam_target[0] = longint'(ev.tx);
        cam_target[1] = longint'(ev.ty);
        cam_target[2] = longint'(ev.tz);
        if (op_t'(ev.operation) == OP_RESET) begin
          cam_dist = longint'(cam_reg[REG_DEF_DISTANCE]);
          cam_theta = wrap_turn(longint'($signed(cam_reg[REG_DEF_THETA])));
          cam_phi = clamp(longint'($signed(cam_reg[REG_DEF_PHI])), lo_phi, hi_phi);
        end
      end
    endcase
    cordic_sincos(cam_phi, sp, cp);
    cordic_sincos(cam_theta, st, ct);
    off[0] = floor_shift(cam_dist * floor_shift(sp * ct, 30) + (64'sd1 <<< 29), 30);
    off[1] = floor_shift(cam_dist * cp + (64'sd1 <<< 29), 30);
    off[2] = floor_shift(cam_dist * floor_shift(sp * st, 30) + (64'sd1 <<< 29), 30);
    lim = 64'sd1 <<< (CBITS - 1);
    for (int k = 0; k < 3; k++) eye[k] = clamp(cam_target[k] + off[k], -lim, lim - 1);
    p.ex = 21'(eye[0]);
    p.ey = 21'(eye[1]);
    p.ez = 21'(eye[2]);
    p.theta = 15'(cam_theta);
    p.phi = 16'(cam_phi);
    p.distance = 16'(cam_dist);
  endtask

  // Register write: setup phase, access phase, then the bus returns to idle.
  task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cam_reg[idx] = val;
    @(posedge clk);
  endtask

  // Drops valid, waits for every expected beat, then for the block to settle.
  task automatic drain;
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (pose_queue.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  function automatic int gap_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 45) return 0;
    if (r < 90) return int'($urandom_range(1, 4));
    return int'($urandom_range(10, 60));
  endfunction

  // Sends one event beat and records its expected pose. With no gap, valid
  // stays high from the previous beat and only the payload changes.
  task automatic send_event(input event_t ev, input bit has_pose, input pose_t fixed);
    pose_t p;
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    {operation, delta_x, delta_y, zoom_step, target_x, target_y, target_z} <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_camera(ev, p);
    if (has_pose && p != fixed) begin
      $error("directed pose differs from predictor: table %h predictor %h", fixed, p);
      failed = 1;
    end
    pose_queue.push_back(p);
  endtask

  function automatic event_t rand_event();
    event_t ev;
    int pick;
    ev.operation = 2'($urandom_range(0, 3));
    pick = int'($urandom_range(0, 9));
    ev.dx = (pick == 0) ? 16'($urandom()) : 16'($signed($urandom_range(0, 400)) - 200);
    ev.dy = (pick == 1) ? 16'($urandom()) : 16'($signed($urandom_range(0, 400)) - 200);
    ev.dd = (pick == 2) ? 17'($urandom()) : 17'($signed($urandom_range(0, 4000)) - 2000);
    ev.tx = (pick == 3) ? 21'($urandom()) : 21'($signed($urandom_range(0, 20000)) - 10000);
    ev.ty = (pick == 4) ? 21'($urandom()) : 21'($signed($urandom_range(0, 20000)) - 10000);
    ev.tz = (pick == 5) ? 21'($urandom()) : 21'($signed($urandom_range(0, 20000)) - 10000);
    return ev;
  endfunction

  // Output stall pattern: a calm stretch now and then.
  always @(posedge clk) begin
    if (stall_on && $urandom_range(0, 99) < 30)
      out_stall <= ($urandom_range(0, 9) < 8);
    else
      out_stall <= 1'b0;
    if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;
  end

  // Result checking.
  always @(posedge clk) begin
    pose_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pose_queue.size() == 0) begin
        $error("result beat with nothing expected");
        failed = 1;
      end else begin
        want = pose_queue.pop_front();
        if (eye_x !== want.ex) begin
          $error("eye_x expected %0d got %0d", want.ex, eye_x); failed = 1;
        end
        if (eye_y !== want.ey) begin
          $error("eye_y expected %0d got %0d", want.ey, eye_y); failed = 1;
        end
        if (eye_z !== want.ez) begin
          $error("eye_z expected %0d got %0d", want.ez, eye_z); failed = 1;
        end
        if (theta_out !== want.theta) begin
          $error("theta_out expected %0d got %0d", want.theta, theta_out); failed = 1;
        end
        if (phi_out !== want.phi) begin
          $error("phi_out expected %0d got %0d", want.phi, phi_out); failed = 1;
        end
        if (distance_out !== want.distance) begin
          $error("distance_out expected %0d got %0d", want.distance, distance_out);
          failed = 1;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    row_t rows [$];
    event_t ev;
    pose_t none;
    int guard;
    none = '0;
    cam_reg[REG_SENSITIVITY] = 16'd328;
    cam_reg[REG_MIN_DISTANCE] = 16'd256;
    cam_reg[REG_MAX_DISTANCE] = 16'd5120;
    cam_reg[REG_MIN_PHI] = 16'd410;
    cam_reg[REG_MAX_PHI] = 16'd12458;
    cam_reg[REG_DEF_DISTANCE] = 16'd2560;
    cam_reg[REG_DEF_THETA] = 16'd0;
    cam_reg[REG_DEF_PHI] = 16'd6434;
    cam_theta = 0;
    cam_phi = 6434;
    cam_dist = 2560;
    for (int k = 0; k < 3; k++) cam_target[k] = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: extremes of fields, every operation, wrap and clamps.
    rows.push_back('{'{OP_RETARGET, 16'sd0, 16'sd0, 17'sd0, 21'sd0, 21'sd0, 21'sd0}, 0, none});
    rows.push_back('{'{OP_ZOOM, 16'sd0, 16'sd0, 17'sd65535, 21'sd0, 21'sd0, 21'sd0},
                     0, none});
    rows.push_back('{'{OP_ZOOM, 16'sd0, 16'sd0, -17'sd65535, 21'sd0, 21'sd0, 21'sd0},
                     0, none});
    rows.push_back('{'{OP_ROTATE, 16'sd32767, 16'sd32767, 17'sd0, 21'sd0, 21'sd0, 21'sd0},
                     0, none});
    rows.push_back('{'{OP_ROTATE, 16'sh8000, 16'sh8000, 17'sd0, 21'sd0, 21'sd0, 21'sd0},
                     0, none});
    rows.push_back('{'{OP_ROTATE, -16'sd1, 16'sd1, -17'sd1, -21'sd1, -21'sd1, -21'sd1},
                     0, none});
    rows.push_back('{'{OP_RETARGET, 16'sd0, 16'sd0, 17'sd0, 21'sd1048575, 21'sh100000,
                       21'sd1048575}, 0, none});
    rows.push_back('{'{OP_RETARGET, 16'sd0, 16'sd0, 17'sd0, 21'sh100000, 21'sd1048575,
                       21'sh100000}, 0, none});
    rows.push_back('{'{OP_RESET, 16'sd0, 16'sd0, 17'sd0, 21'sd0, 21'sd0, 21'sd0}, 0, none});
    rows.push_back('{'{OP_ROTATE, 16'sd1000, 16'sd0, 17'sd0, 21'sd0, 21'sd0, 21'sd0},
                     0, none});
    rows.push_back('{'{OP_RESET, -16'sd1, -16'sd1, -17'sd1, 21'sd100, -21'sd100, 21'sd7},
                     0, none});
    foreach (rows[i]) send_event(rows[i].ev, rows[i].has_pose, rows[i].pose);
    drain();

    // Sensitivity zero: rotate leaves angles alone; theta at exactly 2*pi.
    write_reg(REG_SENSITIVITY, 16'd0);
    write_reg(REG_DEF_THETA, 16'd25736);
    write_reg(REG_DEF_PHI, 16'h7FFF);
    send_event('{OP_RESET, 16'sd5, 16'sd5, 17'sd0, 21'sd0, 21'sd0, 21'sd0}, 0, none);
    send_event('{OP_ROTATE, 16'sd32767, 16'sh8000, 17'sd0, 21'sd0, 21'sd0, 21'sd0},
               0, none);
    drain();

    // Inverted limits and extreme defaults.
    write_reg(REG_MIN_DISTANCE, 16'hFFFF);
    write_reg(REG_MAX_DISTANCE, 16'd0);
    write_reg(REG_MIN_PHI, 16'h7FFF);
    write_reg(REG_MAX_PHI, 16'h8000);
    write_reg(REG_DEF_DISTANCE, 16'hFFFF);
    write_reg(REG_DEF_THETA, 16'h8000);
    write_reg(REG_SENSITIVITY, 16'hFFFF);
    send_event('{OP_RESET, 16'sd0, 16'sd0, 17'sd0, 21'sd1048575, 21'sd1048575,
                 21'sd1048575}, 0, none);
    send_event('{OP_ZOOM, 16'sd0, 16'sd0, 17'sd100, 21'sd0, 21'sd0, 21'sd0}, 0, none);
    send_event('{OP_ROTATE, 16'sd32767, 16'sd32767, 17'sd0, 21'sd0, 21'sd0, 21'sd0},
               0, none);
    drain();

    // Random phases, each with its own register setting.
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_SENSITIVITY, (ph == 4) ? 16'hFFFF : 16'($urandom_range(0, 2000)));
      write_reg(REG_MIN_DISTANCE, 16'($urandom_range(0, 1000)));
      write_reg(REG_MAX_DISTANCE, (ph == 3) ? 16'hFFFF : 16'($urandom_range(1000, 20000)));
      write_reg(REG_MIN_PHI, (ph == 3) ? 16'h8000 : 16'($urandom_range(0, 3000)));
      write_reg(REG_MAX_PHI, (ph == 3) ? 16'h7FFF : 16'($urandom_range(9000, 13000)));
      write_reg(REG_DEF_DISTANCE, 16'($urandom()));
      write_reg(REG_DEF_THETA, 16'($urandom()));
      write_reg(REG_DEF_PHI, 16'($urandom()));
      for (int n = 0; n < 106; n++) begin
        ev = rand_event();
        send_event(ev, 0, none);
      end
      drain();
    end

    guard = 0;
    while (pose_queue.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    if (pose_queue.size() != 0) begin
      $error("%0d results never arrived", pose_queue.size());
      failed = 1;
    end
    if (!failed) $display("[orbit_camera_position_top] OK");
    else $display("[orbit_camera_position_top] ERROR");
    $finish;
  end

endmodule
